### rtl/core/population_std_deviation_top_assert.svh
// assertion macros used by the population standard deviation top
// no dependencies; include by bare file name inside a module body
`ifndef POPULATION_STD_DEVIATION_TOP_ASSERT_SVH
`define POPULATION_STD_DEVIATION_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PSD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PSD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/psd_pkg.sv
// shared constants and types for the population standard deviation block
// no dependencies
`default_nettype none

package psd_pkg;

    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int SD_BITS     = 24;
    localparam int COUNT_BITS  = 11;
    localparam int OUT_BITS    = SD_BITS + COUNT_BITS + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [SD_BITS-1:0] SD_MAX = {SD_BITS{1'b1}};

    // status from the accumulator to the sequencer
    typedef struct packed {
        logic done;
        logic dropped;
    } psd_stat_t;

endpackage

`default_nettype wire

### rtl/core/psd_accum.sv
// sample intake: squares each sample and keeps count, sum and sum of squares
// depends on psd_pkg
`default_nettype none

module psd_accum #(
    parameter int SB  = 24,
    parameter int MAX = 1024,
    parameter int CW  = 11,
    parameter int SW  = 35,
    parameter int QW  = 58
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [SB-1:0]       s_sample,
    input  wire logic                s_last,
    input  wire logic                release_in,
    output psd_pkg::psd_stat_t       stat,
    output logic [CW-1:0]            count,
    output logic [SW-1:0]            sum,
    output logic [QW-1:0]            sumsq
);
    import psd_pkg::*;

    logic [SB-1:0]          mag;
    logic [2*SB-1:0]        sq;
    logic                   accept;

    logic                   closed_reg;
    logic                   a_valid_reg;
    logic                   a_take_reg;
    logic                   a_last_reg;
    logic signed [SB-1:0]   a_sx_reg;
    logic [2*SB-1:0]        a_sq_reg;
    logic [CW-1:0]          count_reg;
    logic signed [SW-1:0]   sum_reg;
    logic [QW-1:0]          sumsq_reg;
    logic                   drop_reg;
    logic                   done_reg;

    assign s_ready = !closed_reg;
    assign accept  = s_valid && !closed_reg;
    assign mag     = s_sample[SB-1] ? (~s_sample + SB'(1)) : s_sample;
    assign sq      = mag * mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            a_take_reg  <= 1'b0;
            a_last_reg  <= 1'b0;
            count_reg   <= '0;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            drop_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end else if (release_in) begin
            closed_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            count_reg   <= '0;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            drop_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            // first stage: square the word and decide whether it fits
            a_valid_reg <= accept;
            a_last_reg  <= accept && s_last;
            a_sx_reg    <= s_sample;
            a_sq_reg    <= sq;
            a_take_reg  <= 1'b0;
            if (accept) begin
                if (s_last) begin
                    closed_reg <= 1'b1;
                end
                if (count_reg >= CW'(MAX)) begin
                    drop_reg <= 1'b1;
                end else begin
                    count_reg  <= count_reg + CW'(1);
                    a_take_reg <= 1'b1;
                end
            end
            // second stage: fold into the running totals
            if (a_valid_reg && a_take_reg) begin
                sum_reg   <= sum_reg + SW'(a_sx_reg);
                sumsq_reg <= sumsq_reg + QW'(a_sq_reg);
            end
            done_reg <= a_valid_reg && a_last_reg;
        end
    end

    assign stat.done    = done_reg;
    assign stat.dropped = drop_reg;
    assign count        = count_reg;
    assign sum          = sum_reg;
    assign sumsq        = sumsq_reg;

endmodule

`default_nettype wire

### rtl/core/psd_sermul.sv
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
// depends on psd_pkg
`default_nettype none

module psd_sermul #(
    parameter int PW = 69,
    parameter int BW = 35
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [PW-1:0] op_a,
    input  wire logic [BW-1:0] op_b,
    output logic               done,
    output logic [PW-1:0]      prod
);
    import psd_pkg::*;

    localparam int CNW = $clog2(BW);

    logic [PW-1:0]  acc_reg;
    logic [PW-1:0]  a_reg;
    logic [BW-1:0]  b_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= '0;
                a_reg    <= op_a;
                b_reg    <= op_b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg   <= {a_reg[PW-2:0], 1'b0};
                b_reg   <= {1'b0, b_reg[BW-1:1]};
                cnt_reg <= cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(BW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

### rtl/core/psd_div.sv
// restoring divider, one quotient bit per cycle
// depends on psd_pkg
`default_nettype none

module psd_div #(
    parameter int NW = 69,
    parameter int DW = 22
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo
);
    import psd_pkg::*;

    localparam int CNW = $clog2(NW);

    logic [NW-1:0]  q_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DW:0]    rem_sh;
    logic [DW:0]    diff;
    logic           fits;

    // remainder stays below the divisor, so its shifted form fits one extra bit
    assign rem_sh = {rem_reg, q_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

### rtl/core/psd_isqrt.sv
// floor integer square root, one root bit (two radicand bits) per cycle
// depends on psd_pkg
`default_nettype none

module psd_isqrt #(
    parameter int RW = 24
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [2*RW-1:0] radicand,
    output logic                 done,
    output logic [RW-1:0]        root
);
    import psd_pkg::*;

    localparam int CNW = $clog2(RW);

    logic [2*RW-1:0] v_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CNW-1:0]  cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic            fits;
    logic [RW+3:0]   diff;

    assign rem_sh = {rem_reg, v_reg[2*RW-1:2*RW-2]};
    assign trial  = (RW + 4)'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                v_reg    <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[RW+1:0] : rem_sh[RW+1:0];
                root_reg <= {root_reg[RW-2:0], fits};
                v_reg    <= {v_reg[2*RW-3:0], 2'b00};
                cnt_reg  <= cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(RW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### rtl/core/population_std_deviation_top.sv
// population standard deviation over a marked run of Q15.8 samples
// s_* channel: one word per sample; s_tdata = sample, s_tlast marks the end of a set.
// m_* channel: one word per set; m_tdata = std_dev, sample_count, overflow.
// samples stream in at one word per cycle; the square and the totals are two
// register stages, so the next word is taken in the cycle after the last one.
// after a word with tlast the input stalls (s_tready low) while the finish runs:
// three bit-serial products over SW bits (SW = SAMPLE_BITS + count bits), a
// restoring divide over the numerator width and a root over SAMPLE_BITS, each
// started once the step before it is done; s_tready returns in the cycle after
// m_tvalid rises.
// the result is held in an output register; once loaded, the input side opens
// again and the next set accumulates while the word waits for m_tready.
// a stalled receiver delays the next finish and the reopening of the input after it.
// words beyond MAX_SAMPLES in one set are dropped and flag overflow.
// synchronous active-low reset clears totals, the output valid and the sequencer.
// depends on psd_pkg, psd_accum, psd_sermul, psd_div, psd_isqrt and the assert header
`default_nettype none

module population_std_deviation_top #(
    parameter int MAX_SAMPLES = psd_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = psd_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // sample[SAMPLE_BITS-1:0], zero pad up to a whole byte
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    input  wire logic                                   s_tlast,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // std_dev[23:0], sample_count[34:24], overflow[35], zero pad [39:36]
    output logic [psd_pkg::OUT_TDATA_W-1:0]             m_tdata
);
    import psd_pkg::*;

    `include "population_std_deviation_top_assert.svh"

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int QW  = 2 * SAMPLE_BITS + CW - 1;
    localparam int PW  = QW + CW;
    localparam int DW  = 2 * CW;
    localparam int VW  = 2 * SAMPLE_BITS - 1;
    localparam int RW  = SAMPLE_BITS;
    localparam int RXW = (RW > SD_BITS) ? RW : SD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } state_t;

    psd_stat_t       stat;
    logic [CW-1:0]   acc_count;
    logic [SW-1:0]   acc_sum;
    logic [QW-1:0]   acc_sumsq;
    logic [SW-1:0]   smag;

    logic            mul_done;
    logic [PW-1:0]   mul_prod;
    logic            div_done;
    logic [PW-1:0]   div_quo;
    logic            root_done;
    logic [RW-1:0]   root;
    logic [RXW-1:0]  root_x;
    logic [CW+COUNT_BITS-1:0] count_x;

    state_t          state_reg;
    logic            mul_start_reg;
    logic [PW-1:0]   mul_a_reg;
    logic [SW-1:0]   mul_b_reg;
    logic [PW-1:0]   nss_reg;
    logic [PW-1:0]   num_reg;
    logic            div_start_reg;
    logic [DW-1:0]   den_reg;
    logic            root_start_reg;
    logic [SD_BITS-1:0] sd_reg;
    logic            release_reg;
    logic            m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    psd_accum #(
        .SB  (SAMPLE_BITS),
        .MAX (MAX_SAMPLES),
        .CW  (CW),
        .SW  (SW),
        .QW  (QW)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .s_last     (s_tlast),
        .release_in (release_reg),
        .stat       (stat),
        .count      (acc_count),
        .sum        (acc_sum),
        .sumsq      (acc_sumsq)
    );

    psd_sermul #(
        .PW (PW),
        .BW (SW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    psd_div #(
        .NW (PW),
        .DW (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    psd_isqrt #(
        .RW (RW)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start_reg),
        .radicand ((2 * RW)'(div_quo[VW-1:0])),
        .done     (root_done),
        .root     (root)
    );

    assign smag    = acc_sum[SW-1] ? (~acc_sum + SW'(1)) : acc_sum;
    assign root_x  = RXW'(root);
    assign count_x = (CW + COUNT_BITS)'(acc_count);

    // finish sequence: n*sumsq, sum^2, n^2, divide, root, then load the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            root_start_reg <= 1'b0;
            release_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            root_start_reg <= 1'b0;
            release_reg    <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (stat.done) begin
                        mul_a_reg     <= PW'(acc_sumsq);
                        mul_b_reg     <= SW'(acc_count);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    if (mul_done) begin
                        nss_reg       <= mul_prod;
                        mul_a_reg     <= PW'(smag);
                        mul_b_reg     <= smag;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL2;
                    end
                end
                ST_MUL2: begin
                    if (mul_done) begin
                        // never negative: sum^2 <= n * sumsq
                        num_reg       <= nss_reg - mul_prod;
                        mul_a_reg     <= PW'(acc_count);
                        mul_b_reg     <= SW'(acc_count);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL3;
                    end
                end
                ST_MUL3: begin
                    if (mul_done) begin
                        den_reg       <= mul_prod[DW-1:0];
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        root_start_reg <= 1'b1;
                        state_reg      <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (root_done) begin
                        sd_reg    <= (root_x > RXW'(SD_MAX)) ? SD_MAX : root_x[SD_BITS-1:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_data_reg   <= OUT_TDATA_W'({stat.dropped,
                                                      count_x[COUNT_BITS-1:0], sd_reg});
                        m_tvalid_reg <= 1'b1;
                        release_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    `PSD_ASSERT_IMP(a_no_intake_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready, "input open during finish")
    `PSD_ASSERT_IMP(a_rose_from_out, aclk, aresetn, $rose(m_tvalid), $past(state_reg == ST_OUT), "result word not from output state")
    `PSD_ASSERT_IMP(a_release_loaded, aclk, aresetn, release_reg, m_tvalid_reg, "totals cleared without a loaded result")
    `PSD_ASSERT_NXT(a_done_starts, aclk, aresetn, state_reg == ST_IDLE && stat.done, state_reg == ST_MUL1, "set end not picked up")

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for population_std_deviation_top: a directed table, a capacity set,
// then random sets under several idle patterns; depends on psd_pkg and the block's rtl
module tb_top;
    import psd_pkg::*;

    localparam int SMP_BITS     = DEF_SAMPLE_BITS;
    localparam int S_TDATA_W    = ((SMP_BITS + 7) / 8) * 8;
    localparam int CAPACITY     = DEF_MAX_SAMPLES;
    localparam int RANDOM_ITEMS = 200;
    localparam int PHASE_ITEMS  = 50;
    localparam int DIR_ROWS     = 20;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [SMP_BITS-1:0] SMP_MAX = {1'b0, {(SMP_BITS-1){1'b1}}};
    localparam logic [SMP_BITS-1:0] SMP_MIN = {1'b1, {(SMP_BITS-1){1'b0}}};

    typedef struct packed {
        logic [SD_BITS-1:0]    std_dev;
        logic [COUNT_BITS-1:0] sample_count;
        logic                  overflow;
    } deviation_word_t;

    typedef struct packed {
        logic [SMP_BITS-1:0] sample;
        logic                last;
        logic                typed;
        deviation_word_t     word;
    } dir_row_t;

    // typed rows carry a result that can be worked out by hand
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{24'h000000, 1'b1, 1'b1, '{24'd0, 11'd1, 1'b0}},
        '{24'h7FFFFF, 1'b1, 1'b1, '{24'd0, 11'd1, 1'b0}},
        '{24'h800000, 1'b1, 1'b1, '{24'd0, 11'd1, 1'b0}},
        '{24'h7FFFFF, 1'b0, 1'b0, '0},
        '{24'h800000, 1'b1, 1'b1, '{24'h7FFFFF, 11'd2, 1'b0}},
        '{24'hFFFFFF, 1'b0, 1'b0, '0},
        '{24'h000001, 1'b1, 1'b1, '{24'd1, 11'd2, 1'b0}},
        '{24'h000100, 1'b0, 1'b0, '0},
        '{24'h000200, 1'b0, 1'b0, '0},
        '{24'h000300, 1'b0, 1'b0, '0},
        '{24'hFFFF00, 1'b0, 1'b0, '0},
        '{24'h000400, 1'b1, 1'b0, '0},
        '{24'h800000, 1'b0, 1'b0, '0},
        '{24'h800000, 1'b0, 1'b0, '0},
        '{24'h800000, 1'b0, 1'b0, '0},
        '{24'h800000, 1'b1, 1'b1, '{24'd0, 11'd4, 1'b0}},
        '{24'h555555, 1'b0, 1'b0, '0},
        '{24'hAAAAAA, 1'b0, 1'b0, '0},
        '{24'h7FFFFF, 1'b0, 1'b0, '0},
        '{24'h800000, 1'b1, 1'b0, '0}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // running totals of the predictor
    logic [COUNT_BITS-1:0] acc_count;
    logic signed [39:0]    acc_sum;
    logic [63:0]           acc_sumsq;
    logic                  acc_dropped;

    deviation_word_t     pending_deviations [$];
    int                  mismatch_count = 0;
    int                  src_idle_pct   = 0;
    int                  sink_stall_pct = 0;
    logic [SMP_BITS-1:0] cluster_base   = '0;

    int idle_src_pct  [4] = '{0, 73, 0, 7};
    int idle_sink_pct [4] = '{0, 0, 73, 7};

    population_std_deviation_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6;
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void clear_totals();
        acc_count   = '0;
        acc_sum     = '0;
        acc_sumsq   = '0;
        acc_dropped = 1'b0;
    endfunction

    function automatic logic [SD_BITS-1:0] floor_root(input logic [127:0] v);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return (root > 128'(SD_MAX)) ? SD_MAX : root[SD_BITS-1:0];
    endfunction

    // adds one accepted word to the totals, or flags it dropped past capacity; a last word yields the expected result
    function automatic void fold_sample(input logic [SMP_BITS-1:0] smp, input logic lst);
        logic [127:0] value;
        logic [127:0] total;
        logic [127:0] n_sumsq;
        logic [127:0] numer;
        logic [127:0] divisor;
        logic [127:0] variance;
        deviation_word_t word;
        value = {{(128-SMP_BITS){smp[SMP_BITS-1]}}, smp};
        if (acc_count >= CAPACITY) begin
            acc_dropped = 1'b1;
        end else begin
            acc_count = acc_count + 1'b1;
            acc_sum   = acc_sum + value[39:0];
            acc_sumsq = acc_sumsq + 64'(value * value);
        end
        if (lst) begin
            total    = {{88{acc_sum[39]}}, acc_sum};
            n_sumsq  = 128'(acc_sumsq) * 128'(acc_count);
            numer    = n_sumsq - total * total;
            divisor  = 128'(acc_count) * 128'(acc_count);
            variance = (divisor == 0 || numer[127]) ? '0 : numer / divisor;
            word.std_dev      = floor_root(variance);
            word.sample_count = acc_count;
            word.overflow     = acc_dropped;
            pending_deviations.push_back(word);
            clear_totals();
        end
    endfunction

    function automatic logic [SMP_BITS-1:0] random_sample();
        case ($urandom_range(0, 3))
            0: return SMP_BITS'($urandom);
            1: return SMP_BITS'(int'($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
            default: return cluster_base + SMP_BITS'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic send_sample(input logic [SMP_BITS-1:0] smp, input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(smp);
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fold_sample(smp, lst);
    endtask

    task automatic send_set(input int len);
        cluster_base = SMP_BITS'($urandom);
        for (int i = 0; i < len; i++) send_sample(random_sample(), i == len - 1);
    endtask

    initial begin
        int random_sent;
        int phase;
        int len;
        int pick;
        random_sent = 0;
        clear_totals();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_sample(dir_rows[r].sample, dir_rows[r].last);
            if (dir_rows[r].typed)
                pending_deviations[pending_deviations.size() - 1] = dir_rows[r].word;
        end

        // set that fills up, then drops two words including the last one
        src_idle_pct   = idle_src_pct[3];
        sink_stall_pct = idle_sink_pct[3];
        send_set(CAPACITY + 2);

        while (random_sent < RANDOM_ITEMS) begin
            phase          = (random_sent / PHASE_ITEMS) % 4;
            src_idle_pct   = idle_src_pct[phase];
            sink_stall_pct = idle_sink_pct[phase];
            pick = $urandom_range(0, 99);
            if (pick < 65)      len = $urandom_range(1, 8);
            else if (pick < 90) len = $urandom_range(9, 24);
            else                len = $urandom_range(25, 48);
            send_set(len);
            random_sent += len;
        end
        s_tvalid <= 1'b0;

        while (pending_deviations.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    always @(posedge aclk) begin
        deviation_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_deviations.size() == 0) begin
                report_mismatch("unexpected result word", 64'(m_tdata), 64'd0);
            end else begin
                want = pending_deviations.pop_front();
                if (m_tdata[SD_BITS-1:0] !== want.std_dev)
                    report_mismatch("std_dev", 64'(m_tdata[SD_BITS-1:0]), 64'(want.std_dev));
                if (m_tdata[SD_BITS +: COUNT_BITS] !== want.sample_count)
                    report_mismatch("sample_count", 64'(m_tdata[SD_BITS +: COUNT_BITS]),
                                    64'(want.sample_count));
                if (m_tdata[SD_BITS + COUNT_BITS] !== want.overflow)
                    report_mismatch("overflow", 64'(m_tdata[SD_BITS + COUNT_BITS]),
                                    64'(want.overflow));
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #9600000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
